FILE: design/modular_inverse_assert.svh
// Assertion macros for the modular inverse block.
`ifndef MODULAR_INVERSE_ASSERT_SVH
`define MODULAR_INVERSE_ASSERT_SVH

`ifndef SYNTHESIS
`define MI_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("modular_inverse assertion failed");
`define MI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("modular_inverse assertion failed");
`else
`define MI_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/mi_pkg.sv
// Shared constants and types for the modular inverse block.
`default_nettype none

package mi_pkg;

    localparam int unsigned WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_STEP,
        ST_FIN,
        ST_NEG,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: design/mi_if.sv
// Valid/ready channel interfaces for the operands and the result.
`default_nettype none

interface mi_in_if #(
    parameter int unsigned WIDTH = mi_pkg::WIDTH_DEF
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] value_in;
    logic [WIDTH-1:0] modulus;

    modport source (output valid, output value_in, output modulus, input ready);
    modport sink (input valid, input value_in, input modulus, output ready);
endinterface

interface mi_out_if #(
    parameter int unsigned WIDTH = mi_pkg::WIDTH_DEF
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] inverse;
    logic             no_inverse;

    modport source (output valid, output inverse, output no_inverse, input ready);
    modport sink (input valid, input inverse, input no_inverse, output ready);
endinterface

`default_nettype wire

FILE: design/modular_inverse.sv
// Top level of the modular inverse block: extended Euclid with a bit-serial divider.
//
// The block takes a value and a modulus and returns the value's inverse modulo the
// modulus, or zero with no_inverse set when the value is zero, not below the modulus,
// or shares a factor with it. One item is worked on at a time. Each Euclid step runs
// the restoring divider, one quotient bit per cycle, while the coefficient product
// is built up from the same quotient bits, and then updates the remainders and the
// coefficients. At a width of 32 bits the worst case is 45 steps, for consecutive
// Fibonacci numbers; an item with invalid operands skips the divider.
// The result waits in an output register, so the next item may start while the
// previous result has not yet been transferred.
`default_nettype none

`include "modular_inverse_assert.svh"

module modular_inverse #(
    parameter int unsigned WIDTH = mi_pkg::WIDTH_DEF
) (
    input  wire     i_clk,
    input  wire     i_rst_n,
    mi_in_if.sink   i_in,
    mi_out_if.source o_out
);

    localparam int unsigned CW = $clog2(WIDTH);
    localparam logic [CW-1:0] CNT_LAST = CW'(WIDTH - 1);

    mi_pkg::t_state r_state, n_state;

    logic [WIDTH-1:0] r_m, n_m;
    logic [WIDTH-1:0] r_r0, n_r0;
    logic [WIDTH-1:0] r_r1, n_r1;
    logic [WIDTH-1:0] r_u0, n_u0;
    logic [WIDTH-1:0] r_u1, n_u1;
    logic             r_neg0, n_neg0;
    logic             r_neg1, n_neg1;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_dvd, n_dvd;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_res, n_res;
    logic             r_res_flag, n_res_flag;
    logic [WIDTH-1:0] r_inv, n_inv;
    logic             r_flag, n_flag;
    logic             r_ovld, n_ovld;

    logic             w_in_fire;
    logic             w_load_out;
    logic             w_bad;
    logic [WIDTH:0]   w_trial;
    logic [WIDTH:0]   w_diff;
    logic             w_ge;
    logic [WIDTH-1:0] w_rem_next;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_load_out = (r_state == mi_pkg::ST_DONE) && (!r_ovld || o_out.ready);
    assign w_bad      = (r_r0 < WIDTH'(2)) || (r_r1 == '0) || (r_r1 >= r_r0);
    assign w_trial    = {r_rem, r_dvd[WIDTH-1]};
    assign w_diff     = w_trial - {1'b0, r_r1};
    assign w_ge       = w_trial >= {1'b0, r_r1};
    assign w_rem_next = w_ge ? w_diff[WIDTH-1:0] : w_trial[WIDTH-1:0];

    assign i_in.ready       = (r_state == mi_pkg::ST_IDLE);
    assign o_out.valid      = r_ovld;
    assign o_out.inverse    = r_inv;
    assign o_out.no_inverse = r_flag;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mi_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    n_state = mi_pkg::ST_CHECK;
                end
            end
            mi_pkg::ST_CHECK: begin
                n_state = w_bad ? mi_pkg::ST_DONE : mi_pkg::ST_DIV;
            end
            mi_pkg::ST_DIV: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = mi_pkg::ST_STEP;
                end
            end
            mi_pkg::ST_STEP: begin
                n_state = (r_rem == '0) ? mi_pkg::ST_FIN : mi_pkg::ST_DIV;
            end
            mi_pkg::ST_FIN: begin
                n_state = (r_r0 != WIDTH'(1)) ? mi_pkg::ST_DONE : mi_pkg::ST_NEG;
            end
            mi_pkg::ST_NEG: begin
                n_state = mi_pkg::ST_DONE;
            end
            mi_pkg::ST_DONE: begin
                if (w_load_out) begin
                    n_state = mi_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mi_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m        = r_m;
        n_r0       = r_r0;
        n_r1       = r_r1;
        n_u0       = r_u0;
        n_u1       = r_u1;
        n_neg0     = r_neg0;
        n_neg1     = r_neg1;
        n_rem      = r_rem;
        n_dvd      = r_dvd;
        n_acc      = r_acc;
        n_cnt      = r_cnt;
        n_res      = r_res;
        n_res_flag = r_res_flag;
        n_inv      = r_inv;
        n_flag     = r_flag;
        n_ovld     = r_ovld && !o_out.ready;
        case (r_state)
            mi_pkg::ST_IDLE: begin
                if (w_in_fire) begin
                    n_m    = i_in.modulus;
                    n_r0   = i_in.modulus;
                    n_r1   = i_in.value_in;
                    n_u0   = '0;
                    n_u1   = WIDTH'(1);
                    n_neg0 = 1'b0;
                    n_neg1 = 1'b0;
                end
            end
            mi_pkg::ST_CHECK: begin
                n_res      = '0;
                n_res_flag = 1'b1;
                n_rem      = '0;
                n_dvd      = r_r0;
                n_acc      = '0;
                n_cnt      = '0;
            end
            mi_pkg::ST_DIV: begin
                n_rem = w_rem_next;
                n_dvd = {r_dvd[WIDTH-2:0], 1'b0};
                n_acc = {r_acc[WIDTH-2:0], 1'b0} + (w_ge ? r_u1 : '0);
                n_cnt = r_cnt + CW'(1);
            end
            mi_pkg::ST_STEP: begin
                n_r0   = r_r1;
                n_r1   = r_rem;
                n_u0   = r_u1;
                n_u1   = r_u0 + r_acc;
                n_neg0 = r_neg1;
                n_neg1 = !r_neg1;
                n_dvd  = r_r1;
                n_rem  = '0;
                n_acc  = '0;
                n_cnt  = '0;
            end
            mi_pkg::ST_FIN: begin
                n_u0 = (r_u0 >= r_m) ? (r_u0 - r_m) : r_u0;
            end
            mi_pkg::ST_NEG: begin
                n_res      = (r_neg0 && (r_u0 != '0)) ? (r_m - r_u0) : r_u0;
                n_res_flag = 1'b0;
            end
            mi_pkg::ST_DONE: begin
                if (w_load_out) begin
                    n_inv  = r_res;
                    n_flag = r_res_flag;
                    n_ovld = 1'b1;
                end
            end
            default: begin
                n_ovld = r_ovld;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mi_pkg::ST_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m        <= n_m;
        r_r0       <= n_r0;
        r_r1       <= n_r1;
        r_u0       <= n_u0;
        r_u1       <= n_u1;
        r_neg0     <= n_neg0;
        r_neg1     <= n_neg1;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_acc      <= n_acc;
        r_cnt      <= n_cnt;
        r_res      <= n_res;
        r_res_flag <= n_res_flag;
        r_inv      <= n_inv;
        r_flag     <= n_flag;
    end

    `MI_ASSERT_SAME(a_flag_zero, i_clk, i_rst_n, r_ovld && r_flag, r_inv == '0)
    `MI_ASSERT_SAME(a_inv_nonzero, i_clk, i_rst_n, r_ovld && !r_flag, r_inv != '0)
    `MI_ASSERT_SAME(a_rem_below, i_clk, i_rst_n, r_state == mi_pkg::ST_DIV, r_rem < r_r1)
    `MI_ASSERT_SAME(a_r_order, i_clk, i_rst_n, r_state == mi_pkg::ST_DIV, r_r1 < r_r0)
    `MI_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, w_load_out, r_ovld)

endmodule

`default_nettype wire

FILE: bench/modular_inverse_checker.sv
`timescale 1ns / 1ps
// Checker for the modular inverse block: predicts each inverse and compares the results.
module modular_inverse_checker #(
    parameter int unsigned W = mi_pkg::WIDTH_DEF
) (
    input  wire i_clk,
    input  wire i_rst_n,
    mi_in_if    i_in,
    mi_out_if   i_out,
    output int  o_fail_count,
    output int  o_outstanding
);

    typedef struct packed {
        logic [W-1:0] inverse;
        logic         no_inverse;
    } t_inverse_result;

    t_inverse_result expected_inverses[$];
    int failures = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    function automatic t_inverse_result predict_inverse(logic [W-1:0] value,
                                                        logic [W-1:0] modulus);
        longint unsigned rem_prev, rem_cur, rem_next;
        longint unsigned coef_prev, coef_cur, coef_next, quot, m;
        bit neg_prev, neg_cur, neg_next;
        t_inverse_result res;
        res.inverse    = '0;
        res.no_inverse = 1'b1;
        m = longint'(modulus);
        if (m < 2 || value == '0 || value >= modulus) return res;
        rem_prev  = m;
        rem_cur   = longint'(value);
        coef_prev = 0;
        coef_cur  = 1;
        neg_prev  = 1'b0;
        neg_cur   = 1'b0;
        // Coefficient magnitudes grow by quotient steps while the sign alternates.
        while (rem_cur != 0) begin
            quot      = rem_prev / rem_cur;
            rem_next  = rem_prev - quot * rem_cur;
            coef_next = coef_prev + quot * coef_cur;
            neg_next  = !neg_cur;
            rem_prev  = rem_cur;
            rem_cur   = rem_next;
            coef_prev = coef_cur;
            neg_prev  = neg_cur;
            coef_cur  = coef_next;
            neg_cur   = neg_next;
        end
        if (rem_prev != 1) return res;
        coef_prev = coef_prev % m;
        if (neg_prev && coef_prev != 0) res.inverse = W'(m - coef_prev);
        else res.inverse = W'(coef_prev);
        res.no_inverse = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_inverse_result want;
        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                if (expected_inverses.size() == 0) begin
                    $display("%0t: unexpected result, inverse %h no_inverse %b",
                             $time, i_out.inverse, i_out.no_inverse);
                    failures++;
                end else begin
                    want = expected_inverses.pop_front();
                    if (want.inverse !== i_out.inverse) begin
                        $display("%0t: inverse expected %h, actual %h",
                                 $time, want.inverse, i_out.inverse);
                    end
                    if (want.no_inverse !== i_out.no_inverse) begin
                        $display("%0t: no_inverse expected %b, actual %b",
                                 $time, want.no_inverse, i_out.no_inverse);
                    end
                    if (want.inverse !== i_out.inverse || want.no_inverse !== i_out.no_inverse)
                        failures++;
                end
            end
            if (i_in.valid && i_in.ready)
                expected_inverses.push_back(predict_inverse(i_in.value_in, i_in.modulus));
        end
        o_fail_count  <= failures;
        o_outstanding <= expected_inverses.size();
    end

endmodule

FILE: bench/modular_inverse_tb.sv
`timescale 1ns / 1ps
// Testbench top for the modular inverse block: operand stimulus, result flow control, verdict.
module modular_inverse_tb;

    localparam int unsigned W = mi_pkg::WIDTH_DEF;
    localparam int unsigned RANDOM_ITEMS = 340;
    localparam int unsigned HOLD_CYCLES = 6000;
    localparam int unsigned DRAIN_CYCLES = 2000;
    localparam longint unsigned CYCLE_LIMIT = 4_000_000;
    localparam logic [W-1:0] FIB_46 = 32'd1836311903;
    localparam logic [W-1:0] FIB_47 = 32'd2971215073;
    localparam logic [W-1:0] TOP_PRIME = 32'd4294967291;
    localparam logic [W-1:0] ALL_ONES = '1;

    typedef enum int {
        SINK_ALWAYS,
        SINK_COIN,
        SINK_SPARSE,
        SINK_PERIODIC
    } t_sink_mode;

    typedef enum int {
        EDGE_ZERO,
        EDGE_EQUAL,
        EDGE_ABOVE,
        EDGE_TINY_MOD,
        EDGE_ONE,
        EDGE_TOP
    } t_edge_kind;

    logic i_clk;
    logic i_rst_n;
    int fail_count;
    int outstanding;
    int hold_requests = 0;
    int unsigned burst_left = 0;
    longint unsigned cycle_count = 0;

    mi_in_if #(.WIDTH(W)) in_ch ();
    mi_out_if #(.WIDTH(W)) out_ch ();

    modular_inverse #(.WIDTH(W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    modular_inverse_checker #(.W(W)) inverse_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // The sender works in bursts; each transfer completes at a clock edge with ready high.
    task automatic send_operands(input logic [W-1:0] value, input logic [W-1:0] modulus);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 20);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        in_ch.valid    <= 1'b1;
        in_ch.value_in <= value;
        in_ch.modulus  <= modulus;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic send_edge_case();
        logic [W-1:0] m;
        t_edge_kind kind;
        kind = t_edge_kind'($urandom_range(0, 5));
        m = $urandom_range(2, 32'hFFFF_FFFF);
        case (kind)
            EDGE_ZERO:     send_operands('0, m);
            EDGE_EQUAL:    send_operands(m, m);
            EDGE_ABOVE:    send_operands($urandom_range(m, 32'hFFFF_FFFF), m);
            EDGE_TINY_MOD: send_operands($urandom, $urandom_range(0, 1));
            EDGE_ONE:      send_operands(1, m);
            default:       send_operands(m - 1, m);
        endcase
    endtask

    task automatic send_random_item();
        logic [W-1:0] m;
        logic [W-1:0] g;
        int unsigned j;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            m = $urandom_range(2, 32'hFFFF_FFFF);
            send_operands($urandom_range(1, m - 1), m);
        end else if (pick < 65) begin
            m = $urandom_range(2, 300);
            send_operands($urandom_range(1, m - 1), m);
        end else if (pick < 75) begin
            m = $urandom_range(2, 65535);
            send_operands($urandom_range(1, m - 1), m);
        end else if (pick < 83) begin
            // A shared factor guarantees that no inverse exists.
            g = $urandom_range(2, 65535);
            j = $urandom_range(2, 60000);
            send_operands(g * $urandom_range(1, j - 1), g * j);
        end else if (pick < 93) begin
            send_operands($urandom, $urandom);
        end else begin
            send_edge_case();
        end
    endtask

    initial begin : result_sink
        int unsigned hold_left;
        int unsigned mode_left;
        int unsigned tick;
        int served;
        t_sink_mode mode;
        hold_left = 0;
        mode_left = 0;
        tick = 0;
        served = 0;
        mode = SINK_ALWAYS;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (served != hold_requests) begin
                served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    SINK_ALWAYS:   out_ch.ready <= 1'b1;
                    SINK_COIN:     out_ch.ready <= $urandom_range(0, 1);
                    SINK_SPARSE:   out_ch.ready <= ($urandom_range(0, 5) == 0);
                    default:       out_ch.ready <= ((tick % 5) < 2);
                endcase
            end
        end
    end

    initial begin : operand_source
        in_ch.valid    <= 1'b0;
        in_ch.value_in <= '0;
        in_ch.modulus  <= '0;
        i_rst_n        <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_operands(1, 2);
        send_operands(1, ALL_ONES);
        send_operands(0, 7);
        send_operands(7, 7);
        send_operands(9, 7);
        send_operands(3, 0);
        send_operands(1, 0);
        send_operands(0, 1);
        send_operands(1, 1);
        send_operands(ALL_ONES, 0);
        send_operands(6, 9);
        send_operands(3, 10);
        send_operands(10, 3);
        send_operands(ALL_ONES - 1, ALL_ONES);
        send_operands(ALL_ONES, ALL_ONES);
        send_operands(2, ALL_ONES);
        send_operands(32'h8000_0000, ALL_ONES);
        send_operands(FIB_46, FIB_47);
        send_operands(2, TOP_PRIME);
        send_operands(65536, TOP_PRIME);
        send_operands(TOP_PRIME - 1, TOP_PRIME);
        send_operands(12345, TOP_PRIME);
        send_operands(32'h5555_5555, 32'hAAAA_AAAB);
        drain_results();

        // Hold the result side off while operands keep coming, so the input stalls.
        hold_requests <= hold_requests + 1;
        burst_left = 40;
        for (int i = 0; i < 8; i++) begin
            send_operands($urandom_range(1, 100), 101);
        end
        drain_results();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) drain_results();
            send_random_item();
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
